@@ src/rau_pkg.sv @@
package rau_pkg;

    localparam int OperandWidth = 32;
    localparam int ProdWidth    = 2 * OperandWidth;
    localparam int MagWidth     = ProdWidth + 1;
    localparam int CountWidth   = $clog2(ProdWidth + 1);

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_ZERO_DEN = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_COMBINE,
        ST_PREP,
        ST_GCD,
        ST_DIV,
        ST_CHECK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic mul3;
        logic combine;
        logic gcd_start;
        logic gcd_step;
        logic div_start;
        logic div_step;
        logic check;
    } t_ctrl;

    typedef struct packed {
        logic early_done;
        logic gcd_done;
        logic div_done;
    } t_stat;

endpackage

@@ src/rau_datapath.sv @@
module rau_datapath
    import rau_pkg::*;
(
    input  logic                    i_clk,
    input  t_ctrl                   i_ctrl,
    input  logic [1:0]              i_command,
    input  logic [OperandWidth-1:0] i_a_num,
    input  logic [OperandWidth-1:0] i_a_den,
    input  logic [OperandWidth-1:0] i_b_num,
    input  logic [OperandWidth-1:0] i_b_den,
    output t_stat                   o_stat,
    output logic [31:0]             o_res_num,
    output logic [30:0]             o_res_den,
    output logic                    o_a_less,
    output logic                    o_a_equal,
    output logic [1:0]              o_status
);

    localparam int OW = OperandWidth;
    localparam int PW = ProdWidth;

    logic [1:0]    r_cmd;
    logic          r_sa, r_sb, r_zero_den;
    logic [OW-1:0] r_uan, r_uad, r_ubn, r_ubd;
    logic [PW-1:0] r_t1, r_t2, r_d, r_np;
    logic [PW:0]   r_nmag;
    logic          r_nneg;
    logic          r_less, r_equal;
    logic [1:0]    r_status;
    logic [PW-1:0] r_gu, r_gv;
    logic [CountWidth-1:0] r_gk;
    logic [PW:0]   r_g;
    logic [PW:0]   r_rem_n, r_rem_d, r_q_n, r_q_d;
    logic [CountWidth:0] r_cnt;
    logic [31:0]   r_res_num;
    logic [30:0]   r_res_den;

    logic [PW-1:0] n_gu, n_gv;
    logic [CountWidth-1:0] n_gk;
    logic [OW-1:0] an, ad, bn, bd;
    logic [OW-1:0] uan, uad, ubn, ubd;
    logic [OW-1:0] mul_a, mul_b;
    logic [PW-1:0] mul_p;
    logic          t1_neg, t2_neg, t2_eff;
    logic [PW:0]   sum_mag;
    logic          sum_neg;
    logic [PW:0]   rem_sh_n, rem_sub_n, rem_sh_d, rem_sub_d;
    logic [PW:0]   half;

    function automatic logic [OW-1:0] mag(input logic [OW-1:0] v);
        return v[OW-1] ? (~v + 1'b1) : v;
    endfunction

    assign an  = i_a_num;
    assign ad  = i_a_den;
    assign bn  = i_b_num;
    assign bd  = i_b_den;
    assign uan = mag(an);
    assign uad = mag(ad);
    assign ubn = mag(bn);
    assign ubd = mag(bd);
    assign half = (PW+1)'(1) << (OW - 1);

    // shared multiplier for the cross products and the denominator, in states MUL1 to MUL3
    always_comb begin
        mul_a = r_uan;
        mul_b = r_ubd;
        if (i_ctrl.mul2) begin
            mul_a = r_ubn;
            mul_b = r_uad;
        end else if (i_ctrl.mul3) begin
            mul_a = r_uad;
            mul_b = (r_cmd == CMD_DIV) ? r_ubn : r_ubd;
        end
    end
    assign mul_p = PW'(mul_a) * PW'(mul_b);

    assign t1_neg = r_sa && (r_t1 != '0);
    assign t2_neg = r_sb && (r_t2 != '0);
    assign t2_eff = (r_cmd == CMD_SUB) ? (!t2_neg && r_t2 != '0) : t2_neg;

    always_comb begin
        if (t1_neg == t2_eff) begin
            sum_neg = t1_neg;
            sum_mag = {1'b0, r_t1} + {1'b0, r_t2};
        end else if (r_t1 >= r_t2) begin
            sum_neg = t1_neg;
            sum_mag = {1'b0, r_t1 - r_t2};
        end else begin
            sum_neg = t2_eff;
            sum_mag = {1'b0, r_t2 - r_t1};
        end
        if (sum_mag == '0) begin
            sum_neg = 1'b0;
        end
    end

    // binary GCD step: strip common twos into r_gk, halve even sides, subtract odd ones
    always_comb begin
        n_gu = r_gu;
        n_gv = r_gv;
        n_gk = r_gk;
        if (!r_gu[0] && !r_gv[0]) begin
            n_gu = r_gu >> 1;
            n_gv = r_gv >> 1;
            n_gk = r_gk + 1'b1;
        end else if (!r_gu[0]) begin
            n_gu = r_gu >> 1;
        end else if (!r_gv[0]) begin
            n_gv = r_gv >> 1;
        end else if (r_gu >= r_gv) begin
            n_gu = (r_gu - r_gv) >> 1;
        end else begin
            n_gv = (r_gv - r_gu) >> 1;
        end
    end

    assign rem_sh_n  = {r_rem_n[PW-1:0], r_q_n[PW]};
    assign rem_sub_n = rem_sh_n - r_g;
    assign rem_sh_d  = {r_rem_d[PW-1:0], r_q_d[PW]};
    assign rem_sub_d = rem_sh_d - r_g;

    assign o_stat.early_done = r_zero_den || (r_d == '0) || (r_nmag == '0);
    assign o_stat.gcd_done   = (r_gu == r_gv);
    assign o_stat.div_done   = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd      <= i_command;
            r_zero_den <= (ad == '0) || (bd == '0);
            r_sa       <= an[OW-1] ^ ad[OW-1];
            r_sb       <= bn[OW-1] ^ bd[OW-1];
            r_uan      <= uan;
            r_uad      <= uad;
            r_ubn      <= ubn;
            r_ubd      <= ubd;
            r_status   <= STATUS_OK;
            r_d        <= '1;
            r_nmag     <= '1;
        end
        if (i_ctrl.mul1) r_t1 <= mul_p;
        if (i_ctrl.mul2) begin
            r_t2 <= mul_p;
            // numerator of multiply uses an*bn; hold it in r_np via mul3 path
        end
        if (i_ctrl.mul3) begin
            r_d  <= mul_p;
            r_np <= PW'(r_uan) * PW'(r_ubn);
        end
        if (i_ctrl.combine) begin
            if (t1_neg != t2_neg) begin
                r_less <= t1_neg;
            end else if (!t1_neg) begin
                r_less <= r_t1 < r_t2;
            end else begin
                r_less <= r_t1 > r_t2;
            end
            r_equal <= (t1_neg == t2_neg) && (r_t1 == r_t2);
            case (r_cmd)
                CMD_ADD, CMD_SUB: begin
                    r_nmag <= sum_mag;
                    r_nneg <= sum_neg;
                end
                CMD_MUL: begin
                    r_nmag <= {1'b0, r_np};
                    r_nneg <= r_sa ^ r_sb;
                end
                default: begin
                    r_nmag <= {1'b0, r_t1};
                    r_nneg <= r_sa ^ r_sb;
                end
            endcase
        end
        // the numerator magnitude never exceeds 2^63, so its top bit is clear
        if (i_ctrl.gcd_start) begin
            r_gu <= r_nmag[PW-1:0];
            r_gv <= r_d;
            r_gk <= '0;
        end
        if (i_ctrl.gcd_step) begin
            r_gu <= n_gu;
            r_gv <= n_gv;
            r_gk <= n_gk;
        end
        if (i_ctrl.div_start) begin
            r_g     <= {1'b0, r_gu} << r_gk;
            r_rem_n <= '0;
            r_rem_d <= '0;
            r_q_n   <= r_nmag;
            r_q_d   <= {1'b0, r_d};
            r_cnt   <= (CountWidth+1)'(PW + 1);
        end
        if (i_ctrl.div_step) begin
            if (rem_sub_n[PW] == 1'b0) begin
                r_rem_n <= rem_sub_n;
                r_q_n   <= {r_q_n[PW-1:0], 1'b1};
            end else begin
                r_rem_n <= rem_sh_n;
                r_q_n   <= {r_q_n[PW-1:0], 1'b0};
            end
            if (rem_sub_d[PW] == 1'b0) begin
                r_rem_d <= rem_sub_d;
                r_q_d   <= {r_q_d[PW-1:0], 1'b1};
            end else begin
                r_rem_d <= rem_sh_d;
                r_q_d   <= {r_q_d[PW-1:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_ctrl.check) begin
            r_res_num <= '0;
            r_res_den <= 31'd1;
            if (r_zero_den) begin
                r_status <= STATUS_ZERO_DEN;
                r_less   <= 1'b0;
                r_equal  <= 1'b0;
            end else if (r_d == '0) begin
                r_status <= STATUS_ZERO_DEN;
            end else if (r_nmag == '0) begin
                r_status <= STATUS_OK;
            end else if (r_q_d > half - 1'b1 ||
                         (r_nneg ? (r_q_n > half) : (r_q_n > half - 1'b1))) begin
                r_status <= STATUS_OVERFLOW;
            end else begin
                r_status  <= STATUS_OK;
                r_res_num <= 32'(r_nneg ? (~r_q_n + 1'b1) : r_q_n);
                r_res_den <= 31'(r_q_d);
            end
        end
    end

    assign o_res_num = r_res_num;
    assign o_res_den = r_res_den;
    assign o_a_less  = r_less;
    assign o_a_equal = r_equal;
    assign o_status  = r_status;

endmodule

@@ src/rau_ctrl.sv @@
module rau_ctrl
    import rau_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_ctrl o_ctrl,
    output logic  o_busy,
    output logic  o_valid
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (i_start) n_state = ST_MUL1;
            ST_MUL1:    n_state = ST_MUL2;
            ST_MUL2:    n_state = ST_MUL3;
            ST_MUL3:    n_state = ST_COMBINE;
            ST_COMBINE: n_state = ST_PREP;
            ST_PREP:    n_state = i_stat.early_done ? ST_CHECK : ST_GCD;
            ST_GCD:     if (i_stat.gcd_done) n_state = ST_DIV;
            ST_DIV:     if (i_stat.div_done) n_state = ST_CHECK;
            ST_CHECK:   n_state = ST_DONE;
            ST_DONE:    n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        unique case (r_state)
            ST_IDLE:    o_ctrl.load = i_start;
            ST_MUL1:    o_ctrl.mul1 = 1'b1;
            ST_MUL2:    o_ctrl.mul2 = 1'b1;
            ST_MUL3:    o_ctrl.mul3 = 1'b1;
            ST_COMBINE: o_ctrl.combine = 1'b1;
            ST_PREP:    o_ctrl.gcd_start = !i_stat.early_done;
            ST_GCD: begin
                o_ctrl.gcd_step  = !i_stat.gcd_done;
                o_ctrl.div_start = i_stat.gcd_done;
            end
            ST_DIV:     o_ctrl.div_step = !i_stat.div_done;
            ST_CHECK:   o_ctrl.check = 1'b1;
            ST_DONE:    o_ctrl = '0;
            default:    o_ctrl = '0;
        endcase
    end

    assign o_busy  = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_DONE);

`ifndef SYNTHESIS
    a_valid_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe held");
    a_check_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == ST_CHECK)) else $error("strobe without check");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("request not taken");
`endif

endmodule

@@ src/rational_arith_unit.sv @@
// channel | handshake        | fields
// request | i_start / o_busy | i_command i_a_num i_a_den i_b_num i_b_den
// result  | o_valid strobe   | o_res_num o_res_den o_a_less o_a_equal o_status
// After acceptance the strobe follows five set-up states (MUL1 to MUL3, COMBINE,
// PREP), the binary GCD loop, two restoring divides run side by side, a check
// state and the strobe state.
// Zero numerators and zero denominators skip the GCD and divides.
// Synchronous active-low reset returns the controller to idle.
// The strobe lasts one cycle and busy drops after it; the receiver cannot stall.
module rational_arith_unit
    import rau_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_a_num,
    input  logic [31:0] i_a_den,
    input  logic [31:0] i_b_num,
    input  logic [31:0] i_b_den,
    output logic        o_valid,
    output logic [31:0] o_res_num,
    output logic [30:0] o_res_den,
    output logic        o_a_less,
    output logic        o_a_equal,
    output logic [1:0]  o_status
);

    t_ctrl ctrl;
    t_stat stat;

    rau_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .o_busy  (o_busy),
        .o_valid (o_valid)
    );

    rau_datapath u_dp (
        .i_clk     (i_clk),
        .i_ctrl    (ctrl),
        .i_command (i_command),
        .i_a_num   (i_a_num),
        .i_a_den   (i_a_den),
        .i_b_num   (i_b_num),
        .i_b_den   (i_b_den),
        .o_stat    (stat),
        .o_res_num (o_res_num),
        .o_res_den (o_res_den),
        .o_a_less  (o_a_less),
        .o_a_equal (o_a_equal),
        .o_status  (o_status)
    );

endmodule
